/* src/pfc_pkg.sv */
// Package for the letter-stream Playfair cipher block.
// Holds letter codes, register indexes, key-square types, reset values and queue size.
// No dependencies.
package pfc_pkg;

	localparam int LETTER_W   = 5;
	localparam int ROW_N      = 5;
	localparam int ROW_W      = LETTER_W * ROW_N;
	localparam int SIDE_DEF   = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W  = 3;

	localparam logic [LETTER_W-1:0] CODE_X = LETTER_W'(23);
	localparam logic [LETTER_W-1:0] CODE_W = LETTER_W'(22);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 3'd0,
		REG_ROW0 = 3'd1,
		REG_ROW1 = 3'd2,
		REG_ROW2 = 3'd3,
		REG_ROW3 = 3'd4,
		REG_ROW4 = 3'd5
	} cfg_reg_t;

	typedef logic [ROW_N-1:0][ROW_W-1:0] square_t;

	// Reset square: the alphabet without W.
	localparam square_t SQUARE_RST = {
		ROW_W'(27025076),
		ROW_W'(20530703),
		ROW_W'(15118698),
		ROW_W'(9706693),
		ROW_W'(4294688)
	};

endpackage

/* src/pfc_ifs.sv */
// Handshake channel interfaces for the Playfair cipher block: letter input,
// result output and configuration write.
// Depends on pfc_pkg.
interface pfc_in_if import pfc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] letter;
	logic                final_letter;

	modport source(output valid, letter, final_letter, input ready);
	modport sink(input valid, letter, final_letter, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] out_letter;
	logic                run_end;
	logic                error_flag;

	modport source(output valid, out_letter, run_end, error_flag, input ready);
	modport sink(input valid, out_letter, run_end, error_flag, output ready);
endinterface

interface pfc_cfg_if import pfc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ROW_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/pfc_front.sv */
// Front end of the Playfair cipher: accepts letters, locates them in the key
// square, forms bigrams and rejections, and pushes jobs into the queue.
// Depends on pfc_pkg and pfc_ifs.
module pfc_front import pfc_pkg::*; #(
	parameter int SIDE  = SIDE_DEF,
	parameter int IDX_W = $clog2(SIDE),
	parameter int JOB_W = 3 + 4 * IDX_W
) (
	input  logic             clk,
	input  logic             arst_n,
	pfc_in_if.sink           letter_ch,
	input  logic             mode_decrypt,
	input  square_t          square,
	input  logic             q_full,
	output logic             push_valid,
	output logic [JOB_W-1:0] push_job
);

	typedef struct packed {
		logic             is_err;
		logic             dec;
		logic             last;
		logic [IDX_W-1:0] ra;
		logic [IDX_W-1:0] ca;
		logic [IDX_W-1:0] rb;
		logic [IDX_W-1:0] cb;
	} job_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} loc_t;

	// First match in row-major order; cells past the side never match.
	function automatic loc_t locate(input logic [LETTER_W-1:0] code, input square_t sq);
		loc_t res;
		res = '0;
		for (int r = ROW_N - 1; r >= 0; r--) begin
			for (int c = ROW_N - 1; c >= 0; c--) begin
				if (r < SIDE && c < SIDE && sq[r][LETTER_W*c +: LETTER_W] == code) begin
					res.found = 1'b1;
					res.row   = IDX_W'(r);
					res.col   = IDX_W'(c);
				end
			end
		end
		return res;
	endfunction

	function automatic job_t mk_pair(input loc_t a, input loc_t b, input logic dec,
		input logic last);
		job_t j;
		j.is_err = 1'b0;
		j.dec    = dec;
		j.last   = last;
		j.ra     = a.row;
		j.ca     = a.col;
		j.rb     = b.row;
		j.cb     = b.col;
		return j;
	endfunction

	localparam job_t ERR_JOB = '{is_err: 1'b1, dec: 1'b0, last: 1'b1,
		ra: '0, ca: '0, rb: '0, cb: '0};

	logic [LETTER_W-1:0] held_letter_q;
	loc_t                held_loc_q;
	logic                held_valid_q;
	logic                discarding_q;
	job_t                spill_q;
	logic                spill_valid_q;

	logic                acc;
	logic                fin;
	loc_t                hit;
	loc_t                xloc;
	logic                emit0;
	logic                emit1;
	job_t                job0;
	job_t                job1;
	logic [LETTER_W-1:0] n_held_letter;
	loc_t                n_held_loc;
	logic                n_held_valid;
	logic                n_discarding;

	assign letter_ch.ready = !spill_valid_q && !q_full;
	assign acc             = letter_ch.valid && letter_ch.ready;
	assign fin             = letter_ch.final_letter;
	assign hit             = locate(letter_ch.letter, square);
	assign xloc            = locate(CODE_X, square);

	// Classify the letter and decide which jobs it produces.
	always_comb begin
		emit0         = 1'b0;
		emit1         = 1'b0;
		job0          = ERR_JOB;
		job1          = ERR_JOB;
		n_held_letter = held_letter_q;
		n_held_loc    = held_loc_q;
		n_held_valid  = held_valid_q;
		n_discarding  = discarding_q;
		if (discarding_q) begin
			if (fin) begin
				emit0        = 1'b1;
				n_discarding = 1'b0;
			end
		end else if (!hit.found || (mode_decrypt && letter_ch.letter == CODE_W)
			|| (mode_decrypt && !held_valid_q && fin)
			|| (mode_decrypt && held_valid_q && letter_ch.letter == held_letter_q)
			|| (!mode_decrypt && !xloc.found && fin && !held_valid_q)
			|| (!mode_decrypt && !xloc.found && held_valid_q
				&& letter_ch.letter == held_letter_q)) begin
			// Rejection: report now on the final letter, otherwise drop until it.
			n_held_valid  = 1'b0;
			n_held_letter = '0;
			emit0         = fin;
			n_discarding  = !fin;
		end else if (mode_decrypt) begin
			if (!held_valid_q) begin
				n_held_letter = letter_ch.letter;
				n_held_loc    = hit;
				n_held_valid  = 1'b1;
			end else begin
				emit0        = 1'b1;
				job0         = mk_pair(held_loc_q, hit, 1'b1, fin);
				n_held_valid = 1'b0;
			end
		end else if (held_valid_q && letter_ch.letter == held_letter_q) begin
			// Doubled letter: pair the held one with filler; keep the new one, or pair it too if final.
			emit0 = 1'b1;
			job0  = mk_pair(held_loc_q, xloc, 1'b0, 1'b0);
			if (fin) begin
				emit1        = 1'b1;
				job1         = mk_pair(hit, xloc, 1'b0, 1'b1);
				n_held_valid = 1'b0;
			end
		end else if (held_valid_q) begin
			emit0        = 1'b1;
			job0         = mk_pair(held_loc_q, hit, 1'b0, fin);
			n_held_valid = 1'b0;
		end else if (fin) begin
			emit0 = 1'b1;
			job0  = mk_pair(hit, xloc, 1'b0, 1'b1);
		end else begin
			n_held_letter = letter_ch.letter;
			n_held_loc    = hit;
			n_held_valid  = 1'b1;
		end
	end

	// A spilled second job goes first; new letters wait until it is pushed.
	assign push_valid = spill_valid_q || (acc && emit0);
	assign push_job   = spill_valid_q ? JOB_W'(spill_q) : JOB_W'(job0);

	// Message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			discarding_q  <= 1'b0;
			held_letter_q <= '0;
			held_loc_q    <= '0;
		end else if (acc) begin
			held_valid_q  <= n_held_valid;
			discarding_q  <= n_discarding;
			held_letter_q <= n_held_letter;
			held_loc_q    <= n_held_loc;
		end
	end

	// Spill register for the second job of a doubled final letter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spill_valid_q <= 1'b0;
		end else if (acc && emit1) begin
			spill_valid_q <= 1'b1;
		end else if (spill_valid_q && !q_full) begin
			spill_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit1) begin
			spill_q <= job1;
		end
	end

endmodule

/* src/pfc_queue.sv */
// Short job queue between the front end and the back end of the Playfair cipher.
// One push per cycle unless full and one pop unless empty; read data comes straight from the head entry.
// Depends on pfc_pkg.
module pfc_queue import pfc_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output logic [DATA_W-1:0] head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* src/pfc_back.sv */
// Back end of the Playfair cipher: applies the row, column or rectangle rule to
// a queued bigram and sends its two letters, or an error result, one per transfer.
// Depends on pfc_pkg and pfc_ifs.
module pfc_back import pfc_pkg::*; #(
	parameter int SIDE  = SIDE_DEF,
	parameter int IDX_W = $clog2(SIDE),
	parameter int JOB_W = 3 + 4 * IDX_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  square_t          square,
	input  logic             q_not_empty,
	input  logic [JOB_W-1:0] q_head,
	output logic             pop,
	pfc_out_if.source        result_ch
);

	typedef struct packed {
		logic             is_err;
		logic             dec;
		logic             last;
		logic [IDX_W-1:0] ra;
		logic [IDX_W-1:0] ca;
		logic [IDX_W-1:0] rb;
		logic [IDX_W-1:0] cb;
	} job_t;

	function automatic logic [IDX_W-1:0] step(input logic [IDX_W-1:0] i, input logic dec);
		logic [IDX_W-1:0] res;
		if (dec) begin
			res = (i == '0) ? IDX_W'(SIDE - 1) : i - IDX_W'(1);
		end else begin
			res = (i == IDX_W'(SIDE - 1)) ? '0 : i + IDX_W'(1);
		end
		return res;
	endfunction

	// Cells outside the stored rows read as code zero.
	function automatic logic [LETTER_W-1:0] cell_code(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input square_t sq);
		logic [LETTER_W-1:0] res;
		res = '0;
		for (int rr = 0; rr < ROW_N; rr++) begin
			for (int cc = 0; cc < ROW_N; cc++) begin
				if (r == IDX_W'(rr) && c == IDX_W'(cc)) begin
					res = sq[rr][LETTER_W*cc +: LETTER_W];
				end
			end
		end
		return res;
	endfunction

	job_t                job;
	logic [IDX_W-1:0]    ra;
	logic [IDX_W-1:0]    ca;
	logic [IDX_W-1:0]    rb;
	logic [IDX_W-1:0]    cb;
	logic [LETTER_W-1:0] code_a;
	logic [LETTER_W-1:0] code_b;
	logic                out_free;

	logic                ovalid_q;
	logic [LETTER_W-1:0] olet_q;
	logic                oend_q;
	logic                oerr_q;
	logic                pend_q;
	logic [LETTER_W-1:0] pend_let_q;
	logic                pend_end_q;

	assign job = job_t'(q_head);

	// Playfair rule on the two cell positions.
	always_comb begin
		ra = job.ra;
		ca = job.ca;
		rb = job.rb;
		cb = job.cb;
		if (job.ra == job.rb) begin
			ca = step(job.ca, job.dec);
			cb = step(job.cb, job.dec);
		end else if (job.ca == job.cb) begin
			ra = step(job.ra, job.dec);
			rb = step(job.rb, job.dec);
		end else begin
			ca = job.cb;
			cb = job.ca;
		end
	end

	assign code_a   = cell_code(ra, ca, square);
	assign code_b   = cell_code(rb, cb, square);
	assign out_free = !ovalid_q || result_ch.ready;
	assign pop      = out_free && !pend_q && q_not_empty;

	assign result_ch.valid      = ovalid_q;
	assign result_ch.out_letter = olet_q;
	assign result_ch.run_end    = oend_q;
	assign result_ch.error_flag = oerr_q;

	// Output register control: second letter of a bigram goes before the next job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				ovalid_q <= 1'b1;
				pend_q   <= 1'b0;
			end else if (q_not_empty) begin
				ovalid_q <= 1'b1;
				pend_q   <= !job.is_err;
			end else begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Output payload and the held second letter.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				olet_q <= pend_let_q;
				oend_q <= pend_end_q;
				oerr_q <= 1'b0;
			end else if (q_not_empty) begin
				if (job.is_err) begin
					olet_q <= '0;
					oend_q <= 1'b1;
					oerr_q <= 1'b1;
				end else begin
					olet_q     <= code_a;
					oend_q     <= 1'b0;
					oerr_q     <= 1'b0;
					pend_let_q <= code_b;
					pend_end_q <= job.last;
				end
			end
		end
	end

endmodule

/* src/playfair_stream_cipher.sv */
// Playfair cipher on a letter stream, top level with the configuration registers.
// A bigram's job enters the queue as its completing letter is accepted, a spilled
// job later; the back end then sends its first letter and then its second. Letters
// are accepted one per cycle while the queue is not full and no spilled job waits;
// results go out one per cycle while the output is ready. Reset clears the mode to
// encrypt, loads the default key square, empties the held letter, queue and output.
module playfair_stream_cipher import pfc_pkg::*; #(
	parameter int SIDE = SIDE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pfc_in_if.sink    letter_ch,
	pfc_out_if.source result_ch,
	pfc_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(SIDE);
	localparam int JOB_W = 3 + 4 * IDX_W;

	logic             mode_decrypt_q;
	square_t          square_q;
	logic             push_valid;
	logic [JOB_W-1:0] push_job;
	logic             q_full;
	logic             q_not_empty;
	logic [JOB_W-1:0] q_head;
	logic             pop;

	assign cfg.ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_decrypt_q <= 1'b0;
			square_q       <= SQUARE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MODE: mode_decrypt_q <= cfg.data[0];
				REG_ROW0: square_q[0]    <= cfg.data;
				REG_ROW1: square_q[1]    <= cfg.data;
				REG_ROW2: square_q[2]    <= cfg.data;
				REG_ROW3: square_q[3]    <= cfg.data;
				REG_ROW4: square_q[4]    <= cfg.data;
				default: ;
			endcase
		end
	end

	pfc_front #(
		.SIDE  (SIDE),
		.IDX_W (IDX_W),
		.JOB_W (JOB_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.letter_ch    (letter_ch),
		.mode_decrypt (mode_decrypt_q),
		.square       (square_q),
		.q_full       (q_full),
		.push_valid   (push_valid),
		.push_job     (push_job)
	);

	pfc_queue #(
		.DATA_W (JOB_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	pfc_back #(
		.SIDE  (SIDE),
		.IDX_W (IDX_W),
		.JOB_W (JOB_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.square      (square_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.result_ch   (result_ch)
	);

endmodule

/* test/playfair_stream_cipher_test.sv */
// Self-checking testbench for the letter-stream Playfair cipher block.
// A cycle-free predictor of the cipher is checked against every output transfer.
// Depends on pfc_pkg, the channel interfaces in pfc_ifs.sv and playfair_stream_cipher.
module playfair_stream_cipher_test;
	import pfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_SIDE       = SIDE_DEF;
	localparam int MAX_IDLE       = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam byte CHAR_A        = "A";
	// A letter code that lies outside the alphabet.
	localparam logic [LETTER_W-1:0] BAD_CODE = LETTER_W'(31);

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                run_end;
		logic                error_flag;
	} cipher_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pfc_in_if  in_ch();
	pfc_out_if out_ch();
	pfc_cfg_if cfg_ch();

	// Predictor state: a copy of the registers and of the pairing state.
	square_t             key_sq;
	bit                  mode_dec;
	logic [LETTER_W-1:0] held_code;
	bit                  held_on;
	bit                  discard_on;
	cipher_out_t         expected_q[$];

	int fail_count = 0;
	int letters_sent = 0;
	int idle_cycles = 0;
	int hold_request = 0;
	bit idle_on = 1'b1;

	playfair_stream_cipher #(.SIDE(KEY_SIDE)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.letter_ch(in_ch),
		.result_ch(out_ch),
		.cfg      (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Cipher predictor.
	function automatic logic [LETTER_W-1:0] key_cell(input int r, input int c);
		if (r < ROW_N && c < ROW_N) begin
			return key_sq[r][LETTER_W*c +: LETTER_W];
		end
		return '0;
	endfunction

	// First match in row-major order wins when the square holds a code twice.
	function automatic bit find_cell(input logic [LETTER_W-1:0] code, output int row,
			output int col);
		row = 0;
		col = 0;
		for (int r = 0; r < ROW_N && r < KEY_SIDE; r++) begin
			for (int c = 0; c < ROW_N && c < KEY_SIDE; c++) begin
				if (key_cell(r, c) == code) begin
					row = r;
					col = c;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic int wrap_inc(input int i);
		return (i + 1 >= KEY_SIDE) ? 0 : i + 1;
	endfunction

	function automatic int wrap_dec(input int i);
		return (i == 0) ? KEY_SIDE - 1 : i - 1;
	endfunction

	function automatic void push_pair(input logic [LETTER_W-1:0] a,
			input logic [LETTER_W-1:0] b, input bit dec, input bit last);
		int ra, ca, rb, cb, t;
		void'(find_cell(a, ra, ca));
		void'(find_cell(b, rb, cb));
		if (ra == rb) begin
			ca = dec ? wrap_dec(ca) : wrap_inc(ca);
			cb = dec ? wrap_dec(cb) : wrap_inc(cb);
		end else if (ca == cb) begin
			ra = dec ? wrap_dec(ra) : wrap_inc(ra);
			rb = dec ? wrap_dec(rb) : wrap_inc(rb);
		end else begin
			t = ca;
			ca = cb;
			cb = t;
		end
		expected_q.push_back('{letter: key_cell(ra, ca), run_end: 1'b0, error_flag: 1'b0});
		expected_q.push_back('{letter: key_cell(rb, cb), run_end: last, error_flag: 1'b0});
	endfunction

	// A rejected message reports once, on its final letter.
	function automatic void reject_msg(input bit last);
		held_on = 1'b0;
		held_code = '0;
		discard_on = !last;
		if (last) begin
			expected_q.push_back('{letter: '0, run_end: 1'b1, error_flag: 1'b1});
		end
	endfunction

	function automatic void predict_letter(input logic [LETTER_W-1:0] code, input bit last);
		int r, c;
		bit filler_ok;
		if (discard_on) begin
			if (last) begin
				reject_msg(1'b1);
			end
			return;
		end
		if (!find_cell(code, r, c) || (mode_dec && code == CODE_W)) begin
			reject_msg(last);
			return;
		end
		filler_ok = find_cell(CODE_X, r, c);
		if (mode_dec) begin
			if (!held_on) begin
				if (last) begin
					reject_msg(1'b1);
				end else begin
					held_code = code;
					held_on = 1'b1;
				end
			end else if (code == held_code) begin
				reject_msg(last);
			end else begin
				push_pair(held_code, code, 1'b1, last);
				held_on = 1'b0;
			end
			return;
		end
		// Encrypt: a doubled letter is split by the filler and stays held unless it is final.
		if (held_on && code == held_code) begin
			if (!filler_ok) begin
				reject_msg(last);
				return;
			end
			push_pair(held_code, CODE_X, 1'b0, 1'b0);
			if (last) begin
				push_pair(code, CODE_X, 1'b0, 1'b1);
				held_on = 1'b0;
			end
		end else if (held_on) begin
			push_pair(held_code, code, 1'b0, last);
			held_on = 1'b0;
		end else if (last) begin
			if (!filler_ok) begin
				reject_msg(1'b1);
			end else begin
				push_pair(code, CODE_X, 1'b0, 1'b1);
			end
		end else begin
			held_code = code;
			held_on = 1'b1;
		end
	endfunction

	// Random helpers for keys and messages.
	function automatic int draw_idle();
		return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
	endfunction

	function automatic square_t random_key();
		logic [LETTER_W-1:0] pool[26];
		logic [LETTER_W-1:0] t;
		square_t sq;
		int j;
		for (int i = 0; i < 26; i++) begin
			pool[i] = LETTER_W'(i);
		end
		for (int i = 25; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		for (int k = 0; k < ROW_N * ROW_N; k++) begin
			sq[k / ROW_N][LETTER_W*(k % ROW_N) +: LETTER_W] = pool[k];
		end
		return sq;
	endfunction

	function automatic logic [LETTER_W-1:0] pick_member();
		return key_cell($urandom_range(0, ROW_N - 1), $urandom_range(0, ROW_N - 1));
	endfunction

	// A square letter that is neither W nor the given letter, where one can be found.
	function automatic logic [LETTER_W-1:0] pick_cipher_letter(
			input logic [LETTER_W-1:0] differ_from);
		logic [LETTER_W-1:0] code;
		code = pick_member();
		for (int tries = 0; tries < 16; tries++) begin
			if (code != differ_from && code != CODE_W) begin
				break;
			end
			code = pick_member();
		end
		return code;
	endfunction

	// Input side: one letter transfer, predicted when it is accepted.
	task automatic send_letter(input logic [LETTER_W-1:0] code, input bit last);
		int gap;
		gap = draw_idle();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.letter <= code;
		in_ch.final_letter <= last;
		do @(posedge clk); while (!in_ch.ready);
		predict_letter(code, last);
		letters_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_letter(LETTER_W'(s[i] - CHAR_A), i == s.len() - 1);
		end
	endtask

	task automatic send_word(input logic [LETTER_W-1:0] msg[$]);
		for (int i = 0; i < msg.size(); i++) begin
			send_letter(msg[i], i == msg.size() - 1);
		end
	endtask

	// Wait until the block has drained and finished any letter that made no result.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the mode and all five rows, keeping valid high across the writes.
	task automatic configure(input bit dec, input square_t sq);
		settle();
		for (int i = 0; i <= ROW_N; i++) begin
			cfg_ch.valid <= 1'b1;
			if (i == 0) begin
				cfg_ch.index <= REG_MODE;
				cfg_ch.data <= ROW_W'(dec);
			end else begin
				cfg_ch.index <= cfg_reg_t'(REG_ROW0 + i - 1);
				cfg_ch.data <= sq[i-1];
			end
			do @(posedge clk); while (!cfg_ch.ready);
			if (i == 0) begin
				mode_dec = dec;
			end else begin
				key_sq[i-1] = sq[i-1];
			end
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly well-formed messages for the current mode, the rest noise.
	task automatic run_random(input int budget);
		logic [LETTER_W-1:0] msg[$];
		logic [LETTER_W-1:0] a;
		int start;
		start = letters_sent;
		while (letters_sent - start < budget) begin
			msg.delete();
			idle_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 3) == 0) begin
				// Any code, with a final flag that may cut the message short.
				repeat ($urandom_range(0, 5)) begin
					send_letter(LETTER_W'($urandom_range(0, 31)), $urandom_range(0, 5) == 0);
				end
				send_letter(LETTER_W'($urandom_range(0, 31)), 1'b1);
				continue;
			end
			if (mode_dec) begin
				repeat ($urandom_range(1, 4)) begin
					a = pick_cipher_letter(CODE_W);
					msg.push_back(a);
					msg.push_back(pick_cipher_letter(a));
				end
			end else begin
				repeat ($urandom_range(1, 9)) begin
					if (msg.size() > 0 && $urandom_range(0, 3) == 0) begin
						msg.push_back(msg[$]);
					end else begin
						msg.push_back(pick_member());
					end
				end
			end
			send_word(msg);
		end
		idle_on = 1'b1;
	endtask

	// Test tasks.
	task automatic test_encrypt_rules();
		// Doubled letter, same row, rectangle, same column through the odd pad.
		send_text("AABFCH");
		// Doubled final letter makes two filler pairs.
		send_text("ZZ");
		send_letter(BAD_CODE, 1'b0);
		send_text("H");
		send_text("X");
		// W is not in the default square.
		send_text("W");
	endtask

	task automatic test_decrypt_rules();
		configure(1'b1, SQUARE_RST);
		send_text("FA");
		send_text("WCD");
		send_text("CC");
		send_text("ABC");
	endtask

	task automatic test_missing_filler();
		square_t sq;
		sq = SQUARE_RST;
		sq[ROW_N-1] = '0;
		configure(1'b0, sq);
		send_text("Q");
		send_text("BB");
	endtask

	task automatic test_backpressure();
		configure(1'b0, SQUARE_RST);
		idle_on = 1'b0;
		hold_request = HOLD_CYCLES;
		send_text("EEEEEEEEEEEEEEE");
		send_text("MMMMMMMMMMMMMMM");
		idle_on = 1'b1;
	endtask

	task automatic test_random_default();
		configure(1'b0, SQUARE_RST);
		run_random(60);
		configure(1'b1, SQUARE_RST);
		run_random(60);
	endtask

	task automatic test_random_keys();
		repeat (3) begin
			configure($urandom_range(0, 1), random_key());
			run_random(40);
		end
	endtask

	task automatic test_extreme_rows();
		square_t sq;
		sq = random_key();
		sq[0] = '0;
		sq[ROW_N-1] = '1;
		configure(1'b0, sq);
		run_random(25);
		configure(1'b1, sq);
		run_random(25);
	endtask

	// Output side: random stalls, plus one long hold on request.
	initial begin : result_sink
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (hold_request > 0) ? hold_request : draw_idle();
			hold_request = 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Each output transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: out_letter %0d run_end %0b error_flag %0b",
					out_ch.out_letter, out_ch.run_end, out_ch.error_flag);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (out_ch.out_letter !== want.letter) begin
					$error("out_letter: expected %0d, got %0d", want.letter, out_ch.out_letter);
					fail_count++;
				end
				if (out_ch.run_end !== want.run_end) begin
					$error("run_end: expected %0b, got %0b", want.run_end, out_ch.run_end);
					fail_count++;
				end
				if (out_ch.error_flag !== want.error_flag) begin
					$error("error_flag: expected %0b, got %0b", want.error_flag,
						out_ch.error_flag);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("playfair_stream_cipher_test failed");
			$finish;
		end
	end

	initial begin : stimulus
		in_ch.valid = 1'b0;
		in_ch.letter = '0;
		in_ch.final_letter = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MODE;
		cfg_ch.data = '0;
		key_sq = SQUARE_RST;
		mode_dec = 1'b0;
		held_code = '0;
		held_on = 1'b0;
		discard_on = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_encrypt_rules();
		test_decrypt_rules();
		test_missing_filler();
		test_backpressure();
		test_random_default();
		test_random_keys();
		test_extreme_rows();

		// Drain the remaining results, then report.
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("playfair_stream_cipher_test passed");
		end else begin
			$display("playfair_stream_cipher_test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/pfc_pkg.sv
src/pfc_ifs.sv
src/pfc_front.sv
src/pfc_queue.sv
src/pfc_back.sv
src/playfair_stream_cipher.sv
test/playfair_stream_cipher_test.sv
